@@ rtl/bqd_pkg.sv @@
// Shared types, constants and the microcode table of the biquad filter.
// No dependencies; every other file imports this package.
package bqd_pkg;

  localparam int BQD_CHANNELS = 8;

  localparam int SMP_W   = 24;
  localparam int CHAN_W  = 3;
  localparam int COEF_W  = 20;
  localparam int DLY_W   = 32;
  localparam int FRAC_SH = 16;
  localparam int PROD_W  = COEF_W + DLY_W;
  localparam int ACC_W   = 56;
  localparam int STEP_W  = 3;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  typedef enum logic [2:0] {COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2} coef_sel_e;
  typedef enum logic [1:0] {WORD_W1, WORD_W2, WORD_WN} word_sel_e;
  typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD_X, ACC_SUB, ACC_ADD, ACC_LOAD_P} acc_op_e;
  typedef enum logic [1:0] {SEQ_WAIT_IN, SEQ_NEXT, SEQ_FINISH} seq_e;

  typedef struct packed {
    coef_sel_e coef_sel;
    word_sel_e word_sel;
    acc_op_e   acc_op;
    logic      w_latch;
    seq_e      seq;
  } ctrl_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  localparam logic signed [COEF_W-1:0] COEF_ONE = 20'sd65536;

  // Program: feedback sum, latch w, feedforward sum, commit.
  // The product register sits one step behind the accumulator.
  function automatic ctrl_t bqd_ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{coef_sel: COEF_B0, word_sel: WORD_W1, acc_op: ACC_HOLD,
          w_latch: 1'b0, seq: SEQ_NEXT};
    unique case (step)
      3'd0: c.seq = SEQ_WAIT_IN;
      3'd1: begin
        c.coef_sel = COEF_A1; c.word_sel = WORD_W1; c.acc_op = ACC_LOAD_X;
      end
      3'd2: begin
        c.coef_sel = COEF_A2; c.word_sel = WORD_W2; c.acc_op = ACC_SUB;
      end
      3'd3: begin
        c.coef_sel = COEF_B1; c.word_sel = WORD_W1; c.acc_op = ACC_SUB;
      end
      3'd4: begin
        c.coef_sel = COEF_B2; c.word_sel = WORD_W2; c.acc_op = ACC_LOAD_P;
        c.w_latch = 1'b1;
      end
      3'd5: begin
        c.coef_sel = COEF_B0; c.word_sel = WORD_WN; c.acc_op = ACC_ADD;
      end
      3'd6: c.acc_op = ACC_ADD;
      3'd7: c.seq = SEQ_FINISH;
      default: c.seq = SEQ_WAIT_IN;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/bqd_if.sv @@
// Valid/ready channel interfaces for input and result items.
// Depends on bqd_pkg for field widths.
interface bqd_in_if import bqd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SMP_W-1:0]  sample_in;
  logic [CHAN_W-1:0]        chan;
  modport source (output valid, sample_in, chan, input ready);
  modport sink   (input valid, sample_in, chan, output ready);
endinterface

interface bqd_out_if import bqd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SMP_W-1:0]  sample_out;
  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

@@ rtl/biquad_df2_filter.sv @@
// Top level of the multichannel biquad: coefficient registers, microcode
// sequencer and handshakes. Depends on bqd_pkg, bqd_if and bqd_datapath.
//
// Each item goes through one idle step that takes the item and reads the
// channel's delay words, then seven program steps through a single
// shared 20x32 multiplier with a registered product feeding one 56-bit
// accumulator. The next item is taken when the program returns to its idle
// step; a finished result waits in the output register, and the program
// stalls only in its last step if the previous result has not been taken.
// Delay state lives in a CHANNELS-deep memory with per-channel valid bits
// cleared by reset, so no clearing pass is needed. Channels at or above
// CHANNELS give 0 and leave all state alone. Coefficients must be written
// through the cfg port only while the block is idle; this is not enforced.
module biquad_df2_filter import bqd_pkg::*; #(
  parameter int CHANNELS = BQD_CHANNELS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bqd_in_if.sink               in_i,
  bqd_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  coef_t             coef_q;
  ctrl_t             ctrl;
  logic              in_fire, commit;

  assign ctrl = bqd_ucode(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{b0: COEF_ONE, b1: '0, b2: '0, a1: '0, a2: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_B0:  coef_q.b0 <= cfg_data_i;
        REG_B1:  coef_q.b1 <= cfg_data_i;
        REG_B2:  coef_q.b2 <= cfg_data_i;
        REG_A1:  coef_q.a1 <= cfg_data_i;
        REG_A2:  coef_q.a2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake outputs
  always_comb begin
    in_i.ready = (ctrl.seq == SEQ_WAIT_IN);
    in_fire    = in_i.valid && in_i.ready;
    commit     = (ctrl.seq == SEQ_FINISH) && (!out_valid_q || out_o.ready);
  end

  // next step and result valid
  always_comb begin
    unique case (ctrl.seq)
      SEQ_WAIT_IN: step_d = in_fire ? step_q + STEP_W'(1) : step_q;
      SEQ_NEXT:    step_d = step_q + STEP_W'(1);
      SEQ_FINISH:  step_d = commit ? STEP_IDLE : step_q;
      default:     step_d = STEP_IDLE;
    endcase
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  bqd_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .load_i   (in_fire),
    .commit_i (commit),
    .sample_i (in_i.sample_in),
    .chan_i   (in_i.chan),
    .coef_i   (coef_q),
    .sample_o (out_o.sample_out)
  );

  assign out_o.valid = out_valid_q;

  // a result appears only out of the last program step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q) == STEP_LAST)
    else $error("result valid without finishing the program");

  // an accepted item starts the program on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> step_q == STEP_IDLE + STEP_W'(1))
    else $error("program did not start after accept");

  // a blocked result holds the program in its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_LAST && out_valid_q && !out_o.ready) |=> step_q == STEP_LAST)
    else $error("program left last step while output blocked");

endmodule

@@ rtl/bqd_datapath.sv @@
// Datapath of the biquad: delay memory, shared multiplier, accumulator,
// rounding and saturation, result register. Depends on bqd_pkg.
module bqd_datapath import bqd_pkg::*; #(
  parameter int CHANNELS = BQD_CHANNELS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_t                   ctrl_i,
  input  logic                    load_i,
  input  logic                    commit_i,
  input  logic signed [SMP_W-1:0] sample_i,
  input  logic [CHAN_W-1:0]       chan_i,
  input  coef_t                   coef_i,
  output logic signed [SMP_W-1:0] sample_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [2*DLY_W-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0] vld_q;

  logic [2*DLY_W-1:0]       rd_q;
  logic                     rd_vld_q;
  logic signed [SMP_W-1:0]  x_q;
  logic [CHAN_W-1:0]        ch_q;
  logic                     in_rng_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [DLY_W-1:0]  w_q;
  logic signed [SMP_W-1:0]  out_q;

  logic [CH_W+CHAN_W-1:0]   in_ext, ch_ext;
  logic [CH_W-1:0]          rd_idx, wr_idx;
  logic                     in_rng;
  logic signed [DLY_W-1:0]  w1, w2, word;
  logic signed [COEF_W-1:0] coef;
  logic signed [ACC_W-1:0]  prod_ext, rnd;
  logic signed [ACC_W-FRAC_SH-1:0] sh;
  logic signed [DLY_W-1:0]  w_sat;
  logic signed [SMP_W-1:0]  y_sat;

  assign in_ext = {{CH_W{1'b0}}, chan_i};
  assign ch_ext = {{CH_W{1'b0}}, ch_q};
  assign rd_idx = in_ext[CH_W-1:0];
  assign wr_idx = ch_ext[CH_W-1:0];
  assign in_rng = (32'(chan_i) < CHANNELS);

  // never-written channels read as zero state
  assign w1 = rd_vld_q ? $signed(rd_q[2*DLY_W-1:DLY_W]) : '0;
  assign w2 = rd_vld_q ? $signed(rd_q[DLY_W-1:0]) : '0;

  always_comb begin
    unique case (ctrl_i.coef_sel)
      COEF_B0: coef = coef_i.b0;
      COEF_B1: coef = coef_i.b1;
      COEF_B2: coef = coef_i.b2;
      COEF_A1: coef = coef_i.a1;
      COEF_A2: coef = coef_i.a2;
      default: coef = coef_i.b0;
    endcase
    unique case (ctrl_i.word_sel)
      WORD_W1: word = w1;
      WORD_W2: word = w2;
      WORD_WN: word = w_q;
      default: word = w1;
    endcase
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    unique case (ctrl_i.acc_op)
      ACC_HOLD:   acc_d = acc_q;
      ACC_LOAD_X: acc_d = {{(ACC_W-SMP_W-FRAC_SH){x_q[SMP_W-1]}}, x_q, {FRAC_SH{1'b0}}};
      ACC_SUB:    acc_d = acc_q - prod_ext;
      ACC_ADD:    acc_d = acc_q + prod_ext;
      ACC_LOAD_P: acc_d = prod_ext;
      default:    acc_d = acc_q;
    endcase
  end

  // round half up, then saturate by checking the bits above the target sign
  assign rnd = acc_q + (ACC_W'(1) <<< (FRAC_SH - 1));
  assign sh  = rnd[ACC_W-1:FRAC_SH];

  always_comb begin
    if (&sh[ACC_W-FRAC_SH-1:DLY_W-1] || ~|sh[ACC_W-FRAC_SH-1:DLY_W-1]) begin
      w_sat = sh[DLY_W-1:0];
    end else begin
      w_sat = sh[ACC_W-FRAC_SH-1] ? {1'b1, {(DLY_W-1){1'b0}}} : {1'b0, {(DLY_W-1){1'b1}}};
    end
    if (&sh[ACC_W-FRAC_SH-1:SMP_W-1] || ~|sh[ACC_W-FRAC_SH-1:SMP_W-1]) begin
      y_sat = sh[SMP_W-1:0];
    end else begin
      y_sat = sh[ACC_W-FRAC_SH-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rd_q     <= mem[rd_idx];
      x_q      <= sample_i;
      ch_q     <= chan_i;
      in_rng_q <= in_rng;
    end
    if (commit_i && in_rng_q) begin
      mem[wr_idx] <= {w_q, w1};
    end
    prod_q <= coef * word;
    acc_q  <= acc_d;
    if (ctrl_i.w_latch) begin
      w_q <= w_sat;
    end
    if (commit_i) begin
      out_q <= in_rng_q ? y_sat : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (load_i) begin
        rd_vld_q <= vld_q[rd_idx];
      end
      if (commit_i && in_rng_q) begin
        vld_q[wr_idx] <= 1'b1;
      end
    end
  end

  assign sample_o = out_q;

endmodule
